### rtl/egtq_pkg.sv
`default_nettype none

package egtq_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 64;

	localparam int LIMIT_W   = 7;
	localparam int ENERGY_W  = 16;
	localparam int TIME_W    = 24;
	localparam int ID_W      = 32;
	localparam int COST_W    = 16;
	localparam int PROD_W    = COST_W + TIME_W;
	localparam int FRAC_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [2:0] OP_ARRIVAL = 3'd0;
	localparam logic [2:0] OP_START   = 3'd1;
	localparam logic [2:0] OP_FINISH  = 3'd2;
	localparam logic [2:0] OP_CHARGE  = 3'd3;
	localparam logic [2:0] OP_CLEAR   = 3'd4;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_DROPPED = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COST        = 2'd3;

	localparam logic [LIMIT_W-1:0]  RST_QUEUE_LIMIT = 7'd64;
	localparam logic [ENERGY_W-1:0] RST_CAPACITY    = 16'd100;
	localparam logic [ENERGY_W-1:0] RST_THRESHOLD   = 16'd5;
	localparam logic [COST_W-1:0]   RST_COST        = 16'd256;

	typedef struct packed {
		logic load;
		logic mul;
		logic exec;
	} dp_cmd_t;

	typedef struct packed {
		logic [TIME_W-1:0]   stime;
		logic [ENERGY_W-1:0] need;
		logic [ID_W-1:0]     id;
	} entry_t;

endpackage

`default_nettype wire

### rtl/egtq_ctrl.sv
`default_nettype none

module egtq_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	output logic                  done,
	output egtq_pkg::dp_cmd_t     cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_EXEC,
		S_READ,
		S_RESP
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:  state_q <= S_EXEC;
				S_EXEC: state_q <= S_READ;
				S_READ: state_q <= S_RESP;
				S_RESP: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = (state_q == S_RESP);
	assign cmd.load    = (state_q == S_IDLE) && start;
	assign cmd.mul     = (state_q == S_MUL);
	assign cmd.exec    = (state_q == S_EXEC);

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("result strobe did not follow an accepted transaction");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.mul, cmd.exec}))
		else $error("more than one datapath command at once");

endmodule

`default_nettype wire

### rtl/egtq_dp.sv
`default_nettype none

module egtq_dp #(
	parameter int QUEUE_DEPTH = egtq_pkg::DEFAULT_QUEUE_DEPTH,
	parameter int PTR_W       = $clog2(QUEUE_DEPTH),
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire egtq_pkg::dp_cmd_t                 cmd,
	input  wire logic [2:0]                        opcode,
	input  wire logic [egtq_pkg::TIME_W-1:0]       tx_time,
	input  wire logic [egtq_pkg::ENERGY_W-1:0]     energy_units,
	input  wire logic                              cfg_we,
	input  wire logic [egtq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [egtq_pkg::ENERGY_W-1:0]     cfg_data,
	output logic [1:0]                             status,
	output logic [egtq_pkg::ID_W-1:0]              packet_id,
	output logic [egtq_pkg::TIME_W-1:0]            started_time,
	output logic                                   can_send,
	output logic                                   is_serving,
	output logic [egtq_pkg::ENERGY_W-1:0]          energy_level,
	output logic [CNT_W-1:0]                       queue_count,
	output logic [egtq_pkg::ID_W-1:0]              drop_count
);

	localparam int CMP_W = (CNT_W > egtq_pkg::LIMIT_W) ? CNT_W : egtq_pkg::LIMIT_W;
	localparam int EW    = egtq_pkg::ENERGY_W;
	localparam int TW    = egtq_pkg::TIME_W;
	localparam int IW    = egtq_pkg::ID_W;
	localparam int PW    = egtq_pkg::PROD_W;
	localparam int FW    = egtq_pkg::FRAC_W;
	localparam int CW    = PW - FW + 1;

	logic [egtq_pkg::LIMIT_W-1:0] limit_q;
	logic [EW-1:0]                cap_q;
	logic [EW-1:0]                thr_q;
	logic [egtq_pkg::COST_W-1:0]  cost_q;

	logic [2:0]       op_q;
	logic [TW-1:0]    time_q;
	logic [EW-1:0]    units_q;
	logic [PW-1:0]    prod_s1;

	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] fill_q;
	logic [EW-1:0]    energy_q;
	logic [IW-1:0]    dropped_q;
	logic [IW-1:0]    seq_q;
	logic             serving_q;
	logic [1:0]       status_q;
	logic [IW-1:0]    pid_q;
	logic [TW-1:0]    stime_q;

	egtq_pkg::entry_t mem [QUEUE_DEPTH];
	egtq_pkg::entry_t rd_q;
	egtq_pkg::entry_t wr_entry;

	logic [TW-1:0]    time_eff;
	logic [CW-1:0]    ceil_w;
	logic [EW-1:0]    need_w;
	logic [CMP_W-1:0] limit_w;
	logic             room_w;
	logic [EW-1:0]    gate_hi;
	logic [EW-1:0]    gate_w;
	logic             open_w;
	logic [EW:0]      charge_sum;
	logic [EW-1:0]    charge_w;
	logic [IW-1:0]    seq_inc;
	logic             push_w;
	logic             pop_w;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_comb begin
		time_eff = (time_q == '0) ? TW'(1) : time_q;
		ceil_w   = {1'b0, prod_s1[PW-1:FW]} + CW'(|prod_s1[FW-1:0]);
		if (ceil_w == '0) begin
			need_w = EW'(1);
		end else if (ceil_w[CW-1:EW] != '0) begin
			need_w = '1;
		end else begin
			need_w = ceil_w[EW-1:0];
		end

		if (CMP_W'(limit_q) > CMP_W'(QUEUE_DEPTH)) begin
			limit_w = CMP_W'(QUEUE_DEPTH);
		end else begin
			limit_w = CMP_W'(limit_q);
		end
		room_w = CMP_W'(fill_q) < limit_w;

		gate_hi = (thr_q > rd_q.need) ? thr_q : rd_q.need;
		gate_w  = (gate_hi > cap_q) ? cap_q : gate_hi;
		open_w  = !serving_q && (fill_q != '0) && (energy_q >= gate_w);

		charge_sum = {1'b0, energy_q} + {1'b0, units_q};
		charge_w   = (charge_sum > {1'b0, cap_q}) ? cap_q : charge_sum[EW-1:0];

		seq_inc = seq_q + 1'b1;
		push_w  = cmd.exec && (op_q == egtq_pkg::OP_ARRIVAL) && room_w;
		pop_w   = cmd.exec && (op_q == egtq_pkg::OP_START) && open_w;

		wr_entry.stime = time_q;
		wr_entry.need  = need_w;
		wr_entry.id    = seq_inc;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			time_q  <= tx_time;
			units_q <= energy_units;
		end
		if (cmd.mul) begin
			prod_s1 <= PW'(cost_q) * PW'(time_eff);
		end
	end

	always_ff @(posedge clk) begin
		if (push_w) begin
			mem[tail_q] <= wr_entry;
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= egtq_pkg::RST_QUEUE_LIMIT;
			cap_q   <= egtq_pkg::RST_CAPACITY;
			thr_q   <= egtq_pkg::RST_THRESHOLD;
			cost_q  <= egtq_pkg::RST_COST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				egtq_pkg::REG_QUEUE_LIMIT: limit_q <= cfg_data[egtq_pkg::LIMIT_W-1:0];
				egtq_pkg::REG_CAPACITY:    cap_q   <= cfg_data;
				egtq_pkg::REG_THRESHOLD:   thr_q   <= cfg_data;
				egtq_pkg::REG_COST:        cost_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
			energy_q  <= '0;
			dropped_q <= '0;
			seq_q     <= '0;
			serving_q <= 1'b0;
			status_q  <= egtq_pkg::ST_DONE;
			pid_q     <= '0;
			stime_q   <= '0;
		end else if (cmd.exec) begin
			status_q <= egtq_pkg::ST_DONE;
			pid_q    <= '0;
			stime_q  <= '0;
			unique case (op_q)
				egtq_pkg::OP_ARRIVAL: begin
					if (room_w) begin
						seq_q  <= seq_inc;
						tail_q <= ptr_next(tail_q);
						fill_q <= fill_q + 1'b1;
						pid_q  <= seq_inc;
					end else begin
						dropped_q <= dropped_q + 1'b1;
						status_q  <= egtq_pkg::ST_DROPPED;
					end
				end
				egtq_pkg::OP_START: begin
					if (open_w) begin
						pid_q     <= rd_q.id;
						stime_q   <= rd_q.stime;
						head_q    <= ptr_next(head_q);
						fill_q    <= fill_q - 1'b1;
						serving_q <= 1'b1;
					end else begin
						status_q <= egtq_pkg::ST_REFUSED;
					end
				end
				egtq_pkg::OP_FINISH: serving_q <= 1'b0;
				egtq_pkg::OP_CHARGE: energy_q  <= charge_w;
				egtq_pkg::OP_CLEAR: begin
					head_q    <= '0;
					tail_q    <= '0;
					fill_q    <= '0;
					energy_q  <= '0;
					dropped_q <= '0;
					seq_q     <= '0;
					serving_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign status       = status_q;
	assign packet_id    = pid_q;
	assign started_time = stime_q;
	assign can_send     = open_w;
	assign is_serving   = serving_q;
	assign energy_level = energy_q;
	assign queue_count  = fill_q;
	assign drop_count   = dropped_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(fill_q) <= CMP_W'(QUEUE_DEPTH))
		else $error("queue fill exceeds its depth");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		push_w |=> fill_q == $past(fill_q) + 1'b1)
		else $error("accepted arrival did not raise the fill count");

	a_serve_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(serving_q) |-> $past(pop_w))
		else $error("serving began without a granted start");

	a_charge_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && op_q == egtq_pkg::OP_CHARGE) |=> energy_q <= cap_q)
		else $error("stored energy above capacity after a charge");

endmodule

`default_nettype wire

### rtl/energy_gated_transmit_queue_top.sv
`default_nettype none

// Transmit queue for an energy-harvesting node with an energy gate on each start.
// A transaction is accepted on a rising edge where start is high and busy is low.
// The opcode selects arrival, start, finish, charge or clear; tx_time is used
// by arrivals and energy_units by charges.
// Each transaction yields exactly one result, shown for one cycle while done is high.
// The result follows the energy-need multiply (S_MUL), the queue update (S_EXEC)
// and a registered read of the new head (S_READ); busy stays high until done, so
// a new transaction is accepted only after the previous one has completed.
// The receiver cannot stall, so done is never held back.
// Configuration writes go through cfg_valid, cfg_ready, cfg_index and cfg_data.
// cfg_ready is always high, and writes are expected only while busy is low.
// An asynchronous reset loads the default register values, empties the queue and
// clears the counters and energy. The queue storage itself is never cleared.

module energy_gated_transmit_queue_top #(
	parameter int QUEUE_DEPTH = egtq_pkg::DEFAULT_QUEUE_DEPTH,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [2:0]                        opcode,
	input  wire logic [egtq_pkg::TIME_W-1:0]       tx_time,
	input  wire logic [egtq_pkg::ENERGY_W-1:0]     energy_units,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [egtq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [egtq_pkg::ENERGY_W-1:0]     cfg_data,
	output logic                                   done,
	output logic [1:0]                             status,
	output logic [egtq_pkg::ID_W-1:0]              packet_id,
	output logic [egtq_pkg::TIME_W-1:0]            started_time,
	output logic                                   can_send,
	output logic                                   is_serving,
	output logic [egtq_pkg::ENERGY_W-1:0]          energy_level,
	output logic [CNT_W-1:0]                       queue_count,
	output logic [egtq_pkg::ID_W-1:0]              drop_count
);

	egtq_pkg::dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	egtq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	egtq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.PTR_W       ($clog2(QUEUE_DEPTH)),
		.CNT_W       (CNT_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.opcode       (opcode),
		.tx_time      (tx_time),
		.energy_units (energy_units),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.status       (status),
		.packet_id    (packet_id),
		.started_time (started_time),
		.can_send     (can_send),
		.is_serving   (is_serving),
		.energy_level (energy_level),
		.queue_count  (queue_count),
		.drop_count   (drop_count)
	);

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

	import egtq_pkg::*;

	localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 20;
	localparam logic [2:0] OP_NOP_LO = 3'd5;
	localparam logic [2:0] OP_NOP_HI = 3'd7;

	typedef enum logic [1:0] {ACT_CMD, ACT_REG_WRITE, ACT_DRAIN} act_kind_t;

	typedef struct {
		act_kind_t kind;
		logic [2:0] opcode;
		logic [TIME_W-1:0] tx_time;
		logic [ENERGY_W-1:0] energy_units;
		logic [CFG_IDX_W-1:0] reg_index;
		logic [ENERGY_W-1:0] reg_data;
		int gap_pct;
	} pending_t;

	typedef struct packed {
		logic [1:0] status;
		logic [ID_W-1:0] packet_id;
		logic [TIME_W-1:0] started_time;
		logic can_send;
		logic is_serving;
		logic [ENERGY_W-1:0] energy_level;
		logic [LIMIT_W-1:0] queue_count;
		logic [ID_W-1:0] drop_count;
	} queue_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] opcode = OP_ARRIVAL;
	logic [TIME_W-1:0] tx_time = '0;
	logic [ENERGY_W-1:0] energy_units = '0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_QUEUE_LIMIT;
	logic [ENERGY_W-1:0] cfg_data = '0;

	logic busy;
	logic cfg_ready;
	logic done;
	logic [1:0] status;
	logic [ID_W-1:0] packet_id;
	logic [TIME_W-1:0] started_time;
	logic can_send;
	logic is_serving;
	logic [ENERGY_W-1:0] energy_level;
	logic [LIMIT_W-1:0] queue_count;
	logic [ID_W-1:0] drop_count;

	energy_gated_transmit_queue_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.tx_time(tx_time),
		.energy_units(energy_units),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.status(status),
		.packet_id(packet_id),
		.started_time(started_time),
		.can_send(can_send),
		.is_serving(is_serving),
		.energy_level(energy_level),
		.queue_count(queue_count),
		.drop_count(drop_count)
	);

	always #5 clk = ~clk;

	logic [TIME_W-1:0] slot_time [DEPTH];
	logic [ENERGY_W-1:0] slot_need [DEPTH];
	logic [ID_W-1:0] slot_id [DEPTH];
	int head_slot = 0;
	int tail_slot = 0;
	int waiting = 0;
	logic [ENERGY_W-1:0] stored_energy = '0;
	logic [ID_W-1:0] drop_total = '0;
	logic [ID_W-1:0] seq_counter = '0;
	logic serving = 1'b0;
	logic [ID_W-1:0] serving_id = '0;

	logic [LIMIT_W-1:0] limit_reg = RST_QUEUE_LIMIT;
	logic [ENERGY_W-1:0] capacity_reg = RST_CAPACITY;
	logic [ENERGY_W-1:0] threshold_reg = RST_THRESHOLD;
	logic [COST_W-1:0] cost_reg = RST_COST;

	pending_t pending[$];
	pending_t in_flight;
	queue_result_t expected_results[$];
	int outstanding = 0;
	int errors = 0;
	int gap_pct = 20;
	int cycle_count = 0;

	function automatic int next_slot(int p);
		return (p == DEPTH - 1) ? 0 : p + 1;
	endfunction

	function automatic logic [ENERGY_W-1:0] energy_need(logic [TIME_W-1:0] t);
		logic [63:0] prod;
		logic [63:0] units;
		prod = 64'(cost_reg) * 64'((t == '0) ? TIME_W'(1) : t);
		units = (prod + 64'({FRAC_W{1'b1}})) >> FRAC_W;
		if (units < 64'd1)
			units = 64'd1;
		if (units > 64'({ENERGY_W{1'b1}}))
			units = 64'({ENERGY_W{1'b1}});
		return units[ENERGY_W-1:0];
	endfunction

	function automatic logic start_allowed();
		logic [ENERGY_W-1:0] gate;
		if (serving || waiting == 0)
			return 1'b0;
		gate = slot_need[head_slot];
		if (threshold_reg > gate)
			gate = threshold_reg;
		if (gate > capacity_reg)
			gate = capacity_reg;
		return stored_energy >= gate;
	endfunction

	function automatic queue_result_t queue_step(pending_t cmd);
		queue_result_t res;
		int lim;
		logic [ENERGY_W:0] sum;
		res = '0;
		res.status = ST_DONE;
		case (cmd.opcode)
			OP_ARRIVAL: begin
				lim = (int'(limit_reg) > DEPTH) ? DEPTH : int'(limit_reg);
				if (waiting >= lim) begin
					drop_total = drop_total + 1;
					res.status = ST_DROPPED;
				end else begin
					seq_counter = seq_counter + 1;
					slot_id[tail_slot] = seq_counter;
					slot_time[tail_slot] = cmd.tx_time;
					slot_need[tail_slot] = energy_need(cmd.tx_time);
					tail_slot = next_slot(tail_slot);
					waiting = waiting + 1;
					res.packet_id = seq_counter;
				end
			end
			OP_START: begin
				if (start_allowed()) begin
					res.packet_id = slot_id[head_slot];
					res.started_time = slot_time[head_slot];
					head_slot = next_slot(head_slot);
					waiting = waiting - 1;
					serving = 1'b1;
					serving_id = res.packet_id;
				end else begin
					res.status = ST_REFUSED;
				end
			end
			OP_FINISH: begin
				serving = 1'b0;
				serving_id = '0;
			end
			OP_CHARGE: begin
				sum = {1'b0, stored_energy} + {1'b0, cmd.energy_units};
				if (sum > {1'b0, capacity_reg})
					sum = {1'b0, capacity_reg};
				stored_energy = sum[ENERGY_W-1:0];
			end
			OP_CLEAR: begin
				head_slot = 0;
				tail_slot = 0;
				waiting = 0;
				stored_energy = '0;
				drop_total = '0;
				seq_counter = '0;
				serving = 1'b0;
				serving_id = '0;
			end
			default: begin
			end
		endcase
		res.can_send = start_allowed();
		res.is_serving = serving;
		res.energy_level = stored_energy;
		res.queue_count = LIMIT_W'(waiting);
		res.drop_count = drop_total;
		return res;
	endfunction

	task automatic push_cmd(logic [2:0] op, logic [TIME_W-1:0] t, logic [ENERGY_W-1:0] u);
		pending_t p;
		p = '{kind: ACT_CMD, default: '0};
		p.opcode = op;
		p.tx_time = t;
		p.energy_units = u;
		p.gap_pct = gap_pct;
		pending.insert(pending.size(), p);
	endtask

	task automatic push_reg(logic [CFG_IDX_W-1:0] idx, logic [ENERGY_W-1:0] d);
		pending_t p;
		p = '{kind: ACT_REG_WRITE, default: '0};
		p.reg_index = idx;
		p.reg_data = d;
		pending.insert(pending.size(), p);
	endtask

	task automatic push_drain();
		pending_t p;
		p = '{kind: ACT_DRAIN, default: '0};
		pending.insert(pending.size(), p);
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		logic took;
		logic hold_start;
		logic hold_cfg;
		if (arst_n) begin
			took = start && !busy;
			if (took) begin
				expected_results.insert(expected_results.size(), queue_step(in_flight));
				outstanding++;
			end
			if (done)
				outstanding--;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_QUEUE_LIMIT: limit_reg = cfg_data[LIMIT_W-1:0];
					REG_CAPACITY: capacity_reg = cfg_data;
					REG_THRESHOLD: threshold_reg = cfg_data;
					REG_COST: cost_reg = cfg_data;
					default: begin
					end
				endcase
			end
			hold_start = start && !took;
			hold_cfg = cfg_valid && !cfg_ready;
			if (!hold_start && !hold_cfg && pending.size() > 0) begin
				case (pending[0].kind)
					ACT_CMD: begin
						if ($urandom_range(99) >= pending[0].gap_pct) begin
							in_flight = pending[0];
							pending.delete(0);
							opcode <= in_flight.opcode;
							tx_time <= in_flight.tx_time;
							energy_units <= in_flight.energy_units;
							hold_start = 1'b1;
						end
					end
					ACT_REG_WRITE: begin
						if (outstanding == 0 && !busy && !start) begin
							cfg_index <= pending[0].reg_index;
							cfg_data <= pending[0].reg_data;
							pending.delete(0);
							hold_cfg = 1'b1;
						end
					end
					default: begin
						if (outstanding == 0)
							pending.delete(0);
					end
				endcase
			end
			start <= hold_start;
			cfg_valid <= hold_cfg;
		end
	end

	always @(negedge clk) begin
		queue_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with no transaction pending, expected none actual id %0h",
					$time, packet_id);
				errors++;
			end else begin
				want = expected_results[0];
				expected_results.delete(0);
				check_field("status", want.status, status);
				check_field("packet_id", want.packet_id, packet_id);
				check_field("started_time", want.started_time, started_time);
				check_field("can_send", want.can_send, can_send);
				check_field("is_serving", want.is_serving, is_serving);
				check_field("energy_level", want.energy_level, energy_level);
				check_field("queue_count", want.queue_count, queue_count);
				check_field("drop_count", want.drop_count, drop_count);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, outstanding);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int r;
		logic [2:0] op;
		logic [TIME_W-1:0] t;
		logic [ENERGY_W-1:0] u;
		logic [LIMIT_W-1:0] lim;
		logic [ENERGY_W-1:0] cap;
		logic [ENERGY_W-1:0] thr;
		logic [COST_W-1:0] cst;

		gap_pct = 20;
		push_cmd(OP_START, '0, '0);
		push_cmd(OP_FINISH, '0, '0);
		push_cmd(OP_CHARGE, '0, '0);
		for (int k = OP_NOP_LO; k <= OP_NOP_HI; k++)
			push_cmd(3'(k), {TIME_W{1'b1}}, {ENERGY_W{1'b1}});
		push_cmd(OP_ARRIVAL, '0, '0);
		push_cmd(OP_ARRIVAL, {TIME_W{1'b1}}, '0);
		push_cmd(OP_START, '0, '0);
		push_cmd(OP_CHARGE, '0, {ENERGY_W{1'b1}});
		push_cmd(OP_START, '0, '0);
		push_cmd(OP_START, '0, '0);
		push_cmd(OP_ARRIVAL, TIME_W'(1), '0);
		push_cmd(OP_FINISH, '0, '0);
		push_cmd(OP_START, '0, '0);
		push_cmd(OP_FINISH, '0, '0);
		// Lower the capacity under the stored energy; the next charge clamps it.
		push_reg(REG_CAPACITY, 16'd10);
		push_cmd(OP_ARRIVAL, TIME_W'(3), '0);
		push_cmd(OP_CHARGE, '0, '0);
		push_cmd(OP_CLEAR, '0, '0);
		push_reg(REG_QUEUE_LIMIT, '0);
		push_reg(REG_COST, '0);
		push_reg(REG_THRESHOLD, '0);
		push_reg(REG_CAPACITY, '0);
		push_cmd(OP_ARRIVAL, TIME_W'(5), '0);
		push_cmd(OP_START, '0, '0);
		push_reg(REG_QUEUE_LIMIT, 16'd100);
		push_reg(REG_COST, {COST_W{1'b1}});
		push_cmd(OP_ARRIVAL, {TIME_W{1'b1}}, '0);
		push_cmd(OP_ARRIVAL, '0, '0);
		push_cmd(OP_START, '0, '0);
		push_cmd(OP_FINISH, '0, '0);
		push_cmd(OP_CLEAR, '0, '0);

		for (int seg = 0; seg < 9; seg++) begin
			gap_pct = (seg < 3) ? 20 : (seg < 6) ? 65 : 0;
			if (seg == 0) begin
				lim = LIMIT_W'(DEPTH);
				cap = {ENERGY_W{1'b1}};
				thr = {ENERGY_W{1'b1}};
				cst = {COST_W{1'b1}};
			end else if (seg == 4) begin
				lim = LIMIT_W'(1);
				cap = ENERGY_W'(1);
				thr = '0;
				cst = '0;
			end else begin
				case ($urandom_range(9))
					0: lim = '0;
					1: lim = LIMIT_W'(1);
					2: lim = LIMIT_W'($urandom_range(DEPTH + 1, 127));
					3, 4: lim = LIMIT_W'($urandom_range(2, 16));
					default: lim = LIMIT_W'(DEPTH);
				endcase
				case ($urandom_range(5))
					0: cap = '0;
					1: cap = {ENERGY_W{1'b1}};
					2: cap = ENERGY_W'($urandom());
					default: cap = ENERGY_W'($urandom_range(1, 200));
				endcase
				case ($urandom_range(5))
					0: thr = '0;
					1: thr = {ENERGY_W{1'b1}};
					2: thr = ENERGY_W'($urandom());
					default: thr = ENERGY_W'($urandom_range(0, 100));
				endcase
				case ($urandom_range(4))
					0: cst = '0;
					1: cst = {COST_W{1'b1}};
					2: cst = COST_W'($urandom());
					default: cst = COST_W'($urandom_range(16, 1024));
				endcase
			end
			push_reg(REG_QUEUE_LIMIT, ENERGY_W'(lim));
			push_reg(REG_CAPACITY, cap);
			push_reg(REG_THRESHOLD, thr);
			push_reg(REG_COST, cst);
			for (int n = 0; n < 134; n++) begin
				if (n == 67)
					push_drain();
				r = $urandom_range(99);
				if (r < 38)
					op = OP_ARRIVAL;
				else if (r < 58)
					op = OP_START;
				else if (r < 72)
					op = OP_FINISH;
				else if (r < 93)
					op = OP_CHARGE;
				else if (r < 95)
					op = OP_CLEAR;
				else
					op = 3'($urandom_range(OP_NOP_LO, OP_NOP_HI));
				case ($urandom_range(9))
					0: t = '0;
					1: t = {TIME_W{1'b1}};
					2, 3: t = TIME_W'($urandom());
					default: t = TIME_W'($urandom_range(1, 1023));
				endcase
				case ($urandom_range(9))
					0: u = '0;
					1: u = {ENERGY_W{1'b1}};
					2: u = ENERGY_W'($urandom());
					default: u = ENERGY_W'($urandom_range(1, 64));
				endcase
				push_cmd(op, t, u);
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || outstanding != 0 || start || cfg_valid)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_results.size());
			errors++;
		end
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/egtq_pkg.sv
rtl/egtq_ctrl.sv
rtl/egtq_dp.sv
rtl/energy_gated_transmit_queue_top.sv
verif/tb.sv
